[sv/gb3_pkg.sv]
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared types and constants for the 3x3 gaussian blur stream.
// ----------------------------------------------------------------------------
package gb3_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int CFG_BITS   = 11;
    localparam int ROW_W      = 16;
    localparam int MAX_HEIGHT = 1024;
    localparam int SUM_W      = PIXEL_BITS + 4;
    localparam int SUM_SHIFT  = 4;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd1024;
    localparam logic [ROW_W-1:0]    ROW_SAT      = 16'hFFFF;

    // register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    typedef struct packed {
        logic   cmd;
        pixel_t pixel_in;
    } in_word_t;

    typedef struct packed {
        pixel_t blurred;
        logic   last_of_frame;
    } out_word_t;

    typedef struct packed {
        pixel_t pixel;
        logic   emit;
        logic   last;
        logic   mask_top;
        logic   mask_bottom;
        logic   mask_left;
        logic   mask_right;
    } tap_ctrl_t;

    // 1-2-1 / 2-4-2 / 1-2-1 as left shifts
    localparam logic [1:0] KERNEL_SHIFT [3][3] = '{
        '{2'd0, 2'd1, 2'd0},
        '{2'd1, 2'd2, 2'd1},
        '{2'd0, 2'd1, 2'd0}
    };

endpackage

[sv/gb3_ctrl.sv]
// ----------------------------------------------------------------------------
// gb3_ctrl
// Frame registers, raster counters, drain tracking and the input stage.
// ----------------------------------------------------------------------------
module gb3_ctrl #(
    parameter int MAX_WIDTH = 1024,
    localparam int COL_W  = $clog2(MAX_WIDTH + 1),
    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [gb3_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  logic                          s_valid,
    input  gb3_pkg::in_word_t             s_data,
    output logic                          s_ready,
    input  logic                          s1_adv,
    output logic                          s1_valid,
    output gb3_pkg::tap_ctrl_t            s1_ctrl,
    output logic [ADDR_W-1:0]             s1_addr,
    output logic                          rd_en,
    output logic [ADDR_W-1:0]             rd_addr
);

    localparam int ROW_W = gb3_pkg::ROW_W;

    logic [gb3_pkg::CFG_BITS-1:0] width_cfg_reg;
    logic [gb3_pkg::CFG_BITS-1:0] height_cfg_reg;
    logic [COL_W-1:0]             width_eff;
    logic [ROW_W-1:0]             height_eff;

    logic [COL_W-1:0] in_col_reg,  in_col_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] in_row_reg,  in_row_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             draining_reg, draining_next;
    logic             s1_valid_reg, s1_valid_next;
    gb3_pkg::tap_ctrl_t s1_ctrl_reg, s1_ctrl_next;
    logic [ADDR_W-1:0]  s1_addr_reg;

    logic [COL_W:0] in_col_inc, out_col_inc;
    logic [ROW_W:0] in_row_inc, out_row_inc;
    logic in_col_wrap, in_row_last, out_col_wrap, out_row_last;
    logic accept, ignore, active, emit, end_of_pixels, last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= gb3_pkg::WIDTH_RESET;
            height_cfg_reg <= gb3_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                gb3_pkg::REG_FRAME_WIDTH:  width_cfg_reg  <= cfg_wdata;
                gb3_pkg::REG_FRAME_HEIGHT: height_cfg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // size clamp: zero acts as one, above max acts as max
    always_comb begin
        if (width_cfg_reg == '0) begin
            width_eff = COL_W'(1);
        end else if (32'(width_cfg_reg) > 32'(MAX_WIDTH)) begin
            width_eff = COL_W'(MAX_WIDTH);
        end else begin
            width_eff = COL_W'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            height_eff = ROW_W'(1);
        end else if (32'(height_cfg_reg) > 32'(gb3_pkg::MAX_HEIGHT)) begin
            height_eff = ROW_W'(gb3_pkg::MAX_HEIGHT);
        end else begin
            height_eff = ROW_W'(height_cfg_reg);
        end
    end

    assign in_col_inc  = (COL_W+1)'(in_col_reg) + (COL_W+1)'(1);
    assign out_col_inc = (COL_W+1)'(out_col_reg) + (COL_W+1)'(1);
    assign in_row_inc  = (ROW_W+1)'(in_row_reg) + (ROW_W+1)'(1);
    assign out_row_inc = (ROW_W+1)'(out_row_reg) + (ROW_W+1)'(1);

    assign in_col_wrap  = in_col_inc  >= (COL_W+1)'(width_eff);
    assign out_col_wrap = out_col_inc >= (COL_W+1)'(width_eff);
    assign in_row_last  = in_row_inc  >= (ROW_W+1)'(height_eff);
    assign out_row_last = out_row_inc >= (ROW_W+1)'(height_eff);

    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;
    assign ignore  = !draining_reg && (s_data.cmd == gb3_pkg::CMD_FLUSH);
    assign active  = accept && !ignore;

    assign emit = (in_row_reg >= ROW_W'(2))
               || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
    assign end_of_pixels = !draining_reg && in_row_last && in_col_wrap;
    assign last = out_row_last && out_col_wrap;

    always_comb begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        draining_next = draining_reg;
        s1_valid_next = s1_valid_reg;
        s1_ctrl_next  = s1_ctrl_reg;

        if (s1_adv) begin
            s1_valid_next = 1'b0;
        end

        if (accept) begin
            s1_valid_next = active;
        end

        if (active) begin
            s1_ctrl_next.pixel       = draining_reg ? '0 : s_data.pixel_in;
            s1_ctrl_next.emit        = emit;
            s1_ctrl_next.last        = emit && last;
            s1_ctrl_next.mask_top    = (out_row_reg == '0);
            s1_ctrl_next.mask_bottom = out_row_last;
            s1_ctrl_next.mask_left   = (out_col_reg == '0);
            s1_ctrl_next.mask_right  = out_col_wrap;

            if (in_col_wrap) begin
                in_col_next = '0;
                if (in_row_reg != gb3_pkg::ROW_SAT) begin
                    in_row_next = in_row_reg + ROW_W'(1);
                end
            end else begin
                in_col_next = in_col_inc[COL_W-1:0];
            end
            if (end_of_pixels) begin
                draining_next = 1'b1;
            end

            if (emit) begin
                if (last) begin
                    in_col_next   = '0;
                    in_row_next   = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    draining_next = 1'b0;
                end else if (out_col_wrap) begin
                    out_col_next = '0;
                    if (out_row_reg != gb3_pkg::ROW_SAT) begin
                        out_row_next = out_row_reg + ROW_W'(1);
                    end
                end else begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            draining_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            draining_reg <= draining_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_ctrl_reg <= s1_ctrl_next;
        if (active) begin
            s1_addr_reg <= in_col_reg[ADDR_W-1:0];
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctrl  = s1_ctrl_reg;
    assign s1_addr  = s1_addr_reg;
    assign rd_en    = active;
    assign rd_addr  = in_col_reg[ADDR_W-1:0];

endmodule

[sv/gb3_line_buf.sv]
// ----------------------------------------------------------------------------
// gb3_line_buf
// Two line stores packed as one word per column, with write-to-read bypass.
// ----------------------------------------------------------------------------
module gb3_line_buf #(
    parameter int MAX_WIDTH = 1024,
    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int LINE_W = 2 * gb3_pkg::PIXEL_BITS
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [LINE_W-1:0] wr_data,
    output logic [LINE_W-1:0] rd_data
);

    logic [LINE_W-1:0] mem [MAX_WIDTH];
    logic [LINE_W-1:0] mem_q_reg;
    logic [LINE_W-1:0] byp_data_reg;
    logic              byp_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_q_reg    <= mem[rd_addr];
            byp_hit_reg  <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : mem_q_reg;

endmodule

[sv/gb3_kernel.sv]
// ----------------------------------------------------------------------------
// gb3_kernel
// 3x3 window shift, edge masking, weighted sum and the result register.
// ----------------------------------------------------------------------------
module gb3_kernel (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s1_valid,
    input  gb3_pkg::tap_ctrl_t                s1_ctrl,
    input  logic [2*gb3_pkg::PIXEL_BITS-1:0]  line_data,
    output logic                              s1_adv,
    output logic                              m_valid,
    input  logic                              m_ready,
    output gb3_pkg::out_word_t                m_data
);

    localparam int PB    = gb3_pkg::PIXEL_BITS;
    localparam int SUM_W = gb3_pkg::SUM_W;

    gb3_pkg::pixel_t    window_reg [3][3];
    gb3_pkg::pixel_t    win_next   [3][3];
    gb3_pkg::pixel_t    column     [3];
    logic [SUM_W-1:0]   sum;
    logic               m_valid_reg;
    gb3_pkg::out_word_t m_data_reg;

    assign column[0] = line_data[2*PB-1:PB];
    assign column[1] = line_data[PB-1:0];
    assign column[2] = s1_ctrl.pixel;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r][0] = window_reg[r][1];
            win_next[r][1] = window_reg[r][2];
            win_next[r][2] = column[r];
        end
    end

    always_comb begin
        logic row_on, col_on;
        sum = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                row_on = !((r == 0 && s1_ctrl.mask_top) || (r == 2 && s1_ctrl.mask_bottom));
                col_on = !((c == 0 && s1_ctrl.mask_left) || (c == 2 && s1_ctrl.mask_right));
                if (row_on && col_on) begin
                    sum = sum + (SUM_W'(win_next[r][c]) << gb3_pkg::KERNEL_SHIFT[r][c]);
                end
            end
        end
    end

    assign s1_adv = s1_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    window_reg[r][c] <= '0;
                end
            end
        end else if (s1_adv) begin
            m_valid_reg <= s1_ctrl.emit;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    window_reg[r][c] <= s1_ctrl.last ? '0 : win_next[r][c];
                end
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg.blurred       <= sum[SUM_W-1:gb3_pkg::SUM_SHIFT];
            m_data_reg.last_of_frame <= s1_ctrl.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[sv/gaussian_blur_3x3_stream.sv]
// path: an accepted word passes the input stage register, then the result register
// throughput: one word per cycle unless m_ready holds the result register
//   line store: one read and one write per word, none for an ignored flush word
// reset: synchronous, active low; clears counters, window and drain flag, and sets
//   both frame size registers to 1024; the line store is not cleared
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream
// Raster-order 3x3 gaussian blur with zero-padded edges and end-of-frame mark.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [gb3_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  gb3_pkg::in_word_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output gb3_pkg::out_word_t            m_data
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PB     = gb3_pkg::PIXEL_BITS;

    logic               s1_valid;
    logic               s1_adv;
    gb3_pkg::tap_ctrl_t s1_ctrl;
    logic [ADDR_W-1:0]  s1_addr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [2*PB-1:0]    line_rd;
    logic [2*PB-1:0]    line_wr;

    gb3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .s_ready   (s_ready),
        .s1_adv    (s1_adv),
        .s1_valid  (s1_valid),
        .s1_ctrl   (s1_ctrl),
        .s1_addr   (s1_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    // older row moves up, current pixel becomes the newer row
    assign line_wr = {line_rd[PB-1:0], s1_ctrl.pixel};

    gb3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr),
        .wr_data (line_wr),
        .rd_data (line_rd)
    );

    gb3_kernel u_kernel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s1_valid  (s1_valid),
        .s1_ctrl   (s1_ctrl),
        .line_data (line_rd),
        .s1_adv    (s1_adv),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[sim/gaussian_blur_3x3_stream_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream_tb
// Self-checking bench for the 3x3 gaussian blur stream. Frames of many sizes,
// written between frames, are streamed with random gaps on both channels. A
// cycle-free predictor computes each blurred word, and every result word is
// checked in order against it.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_stream_tb;

    localparam int MAX_W         = 1024;
    localparam int LINE_DEPTH    = 2 * MAX_W;
    localparam int TOTAL_ITEMS   = 1550;
    localparam int SETTLE_CYCLES = 6;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_FULL,
        FILL_CHECKER
    } fill_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic                          cfg_addr;
    logic [gb3_pkg::CFG_BITS-1:0]  cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    gb3_pkg::in_word_t             s_data;
    logic                          m_valid;
    logic                          m_ready;
    gb3_pkg::out_word_t            m_data;

    // predictor state
    gb3_pkg::pixel_t               line_mem [LINE_DEPTH];
    gb3_pkg::pixel_t               win [3][3];
    int                            in_col;
    int                            in_row;
    int                            out_col;
    int                            out_row;
    bit                            draining;
    logic [gb3_pkg::CFG_BITS-1:0]  width_reg;
    logic [gb3_pkg::CFG_BITS-1:0]  height_reg;

    gb3_pkg::out_word_t            blur_expect [$];
    int                            error_count = 0;
    int                            sent_items = 0;
    bit                            tx_calm = 1'b0;
    bit                            rx_calm = 1'b0;

    gaussian_blur_3x3_stream dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int eff_size(input logic [gb3_pkg::CFG_BITS-1:0] v, input int maxv);
        if (v == 0) return 1;
        return (int'(v) > maxv) ? maxv : int'(v);
    endfunction

    function automatic int kernel_weight(input int r, input int c);
        return ((r == 1) ? 2 : 1) * ((c == 1) ? 2 : 1);
    endfunction

    task automatic clear_frame_state();
        int r, c;
        for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) begin
                win[r][c] = '0;
            end
        end
        in_col   = 0;
        in_row   = 0;
        out_col  = 0;
        out_row  = 0;
        draining = 1'b0;
    endtask

    task automatic blur_model_step(input gb3_pkg::in_word_t word);
        int                 w, h, ic, r, c, sum;
        gb3_pkg::pixel_t    v, top, mid;
        bit                 emit, end_px, last;
        gb3_pkg::out_word_t res;
        w = eff_size(width_reg, MAX_W);
        h = eff_size(height_reg, gb3_pkg::MAX_HEIGHT);
        // flush words before the frame is complete do nothing
        if (!draining && word.cmd == gb3_pkg::CMD_FLUSH) return;
        v = draining ? gb3_pkg::pixel_t'(0) : word.pixel_in;

        ic  = (in_col >= MAX_W) ? MAX_W - 1 : in_col;
        top = line_mem[MAX_W + ic];
        mid = line_mem[ic];
        line_mem[MAX_W + ic] = mid;
        line_mem[ic]         = v;
        for (r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = v;

        emit   = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        end_px = !draining && (in_row + 1 >= h) && (in_col + 1 >= w);
        if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row < int'(gb3_pkg::ROW_SAT)) in_row++;
        end else begin
            in_col++;
        end
        if (end_px) draining = 1'b1;
        if (!emit) return;

        last = (out_row + 1 >= h) && (out_col + 1 >= w);
        sum  = 0;
        for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) begin
                // zero padding outside the frame
                if (!((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h) ||
                      (c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= w))) begin
                    sum += int'(win[r][c]) * kernel_weight(r, c);
                end
            end
        end
        res.blurred       = gb3_pkg::pixel_t'(sum >> gb3_pkg::SUM_SHIFT);
        res.last_of_frame = last;
        blur_expect.push_back(res);

        if (last) begin
            clear_frame_state();
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            if (out_row < int'(gb3_pkg::ROW_SAT)) out_row++;
        end else begin
            out_col++;
        end
    endtask

    task automatic send_word(input logic cmd_code, input gb3_pkg::pixel_t pix);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{cmd: cmd_code, pixel_in: pix};
        do @(posedge aclk); while (!s_ready);
        sent_items++;
        blur_model_step(s_data);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (blur_expect.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame_size(input logic [gb3_pkg::CFG_BITS-1:0] w_raw,
                                  input logic [gb3_pkg::CFG_BITS-1:0] h_raw);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= gb3_pkg::REG_FRAME_WIDTH;
        cfg_wdata <= w_raw;
        @(posedge aclk);
        cfg_addr  <= gb3_pkg::REG_FRAME_HEIGHT;
        cfg_wdata <= h_raw;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        width_reg  = w_raw;
        height_reg = h_raw;
    endtask

    task automatic send_frame(input int w, input int h, input fill_t fill,
                              input bit noise, input bit drain_px);
        int              r, c, k;
        gb3_pkg::pixel_t pix;
        for (r = 0; r < h; r++) begin
            for (c = 0; c < w; c++) begin
                // stray flush before the frame is complete
                if (noise && $urandom_range(0, 15) == 0) begin
                    send_word(gb3_pkg::CMD_FLUSH, gb3_pkg::pixel_t'($urandom));
                end
                case (fill)
                    FILL_ZERO:    pix = '0;
                    FILL_FULL:    pix = '1;
                    FILL_CHECKER: pix = ((r + c) % 2 != 0) ? '1 : '0;
                    default: begin
                        if ($urandom_range(0, 7) == 0) begin
                            pix = ($urandom_range(0, 1) != 0) ? '1 : '0;
                        end else begin
                            pix = gb3_pkg::pixel_t'($urandom);
                        end
                    end
                endcase
                send_word(gb3_pkg::CMD_PIXEL, pix);
            end
        end
        // drain; pixel words here act as flush words
        for (k = 0; k <= w; k++) begin
            if (drain_px || (noise && $urandom_range(0, 2) == 0)) begin
                send_word(gb3_pkg::CMD_PIXEL, gb3_pkg::pixel_t'($urandom));
            end else begin
                send_word(gb3_pkg::CMD_FLUSH, gb3_pkg::pixel_t'($urandom));
            end
        end
    endtask

    task automatic test_corner_pixels();
        set_frame_size(11'd1, 11'd1);
        send_word(gb3_pkg::CMD_FLUSH, '1);
        send_frame(1, 1, FILL_FULL, 1'b0, 1'b0);
        send_frame(1, 1, FILL_ZERO, 1'b0, 1'b1);
        wait_idle();
    endtask

    task automatic test_frame_edges();
        set_frame_size(11'd3, 11'd3);
        send_word(gb3_pkg::CMD_FLUSH, '0);
        send_frame(3, 3, FILL_FULL, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_size_clamp();
        set_frame_size(11'd0, 11'd2);
        send_frame(1, 2, FILL_RANDOM, 1'b0, 1'b0);
        wait_idle();
        set_frame_size(11'd2, 11'd0);
        send_frame(2, 1, FILL_CHECKER, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_max_sizes();
        // height above the maximum acts as the maximum
        set_frame_size(11'd1, 11'd2047);
        send_frame(1, gb3_pkg::MAX_HEIGHT, FILL_RANDOM, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int    w, h, nframes, f;
        fill_t fill;
        while (sent_items < TOTAL_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            set_frame_size(gb3_pkg::CFG_BITS'(w), gb3_pkg::CFG_BITS'(h));
            nframes = $urandom_range(1, 3);
            // frames follow one another with no wait for idle between them
            for (f = 0; f < nframes && sent_items < TOTAL_ITEMS; f++) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
                fill = ($urandom_range(0, 4) != 0) ? FILL_RANDOM : fill_t'($urandom_range(1, 3));
                send_frame(w, h, fill, $urandom_range(0, 3) == 0, 1'b0);
            end
            wait_idle();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial begin : result_checker
        gb3_pkg::out_word_t want;
        int                 stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (blur_expect.size() == 0) begin
                $error("unexpected result word: blurred %0d last_of_frame %0b",
                       m_data.blurred, m_data.last_of_frame);
                error_count++;
            end else begin
                want = blur_expect.pop_front();
                if (m_data.blurred !== want.blurred) begin
                    $error("blurred: expected %0d, actual %0d", want.blurred, m_data.blurred);
                    error_count++;
                end
                if (m_data.last_of_frame !== want.last_of_frame) begin
                    $error("last_of_frame: expected %0b, actual %0b",
                           want.last_of_frame, m_data.last_of_frame);
                    error_count++;
                end
            end
        end
    end

    initial begin : test_sequence
        int i;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= gb3_pkg::REG_FRAME_WIDTH;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        width_reg  = gb3_pkg::WIDTH_RESET;
        height_reg = gb3_pkg::HEIGHT_RESET;
        for (i = 0; i < LINE_DEPTH; i++) begin
            line_mem[i] = '0;
        end
        clear_frame_state();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_corner_pixels();
        test_frame_edges();
        test_size_clamp();
        test_max_sizes();
        test_random_frames();

        wait_idle();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
sv/gb3_pkg.sv
sv/gb3_ctrl.sv
sv/gb3_line_buf.sv
sv/gb3_kernel.sv
sv/gaussian_blur_3x3_stream.sv
sim/gaussian_blur_3x3_stream_tb.sv
